### rtl/divisor_count_trial_division_defines.svh
// Assertion macros used by the checker file.
`ifndef DIVISOR_COUNT_TRIAL_DIVISION_DEFINES_SVH
`define DIVISOR_COUNT_TRIAL_DIVISION_DEFINES_SVH

// Antecedent in one cycle implies consequent in the next.
`define DCTD_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DCTD_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/dctd_pkg.sv
// Shared constants and controller/datapath types for the divisor counter.
package dctd_pkg;

  localparam int NUMBER_W = 32;
  localparam int COUNT_W  = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic take_quot;
    logic next_cand;
    logic finish;
  } dctd_cmd_t;

  typedef struct packed {
    logic v_zero;
    logic sq_gt_v;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } dctd_status_t;

endpackage

### rtl/dctd_ifs.sv
// Valid/ready stream interfaces for the request and result channels.
interface dctd_req_if;
  logic                            valid;
  logic                            ready;
  logic [dctd_pkg::NUMBER_W-1:0]   number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface dctd_res_if;
  logic                            valid;
  logic                            ready;
  logic [dctd_pkg::COUNT_W-1:0]    divisor_count;

  modport source (output valid, output divisor_count, input ready);
  modport sink   (input valid, input divisor_count, output ready);
endinterface

### rtl/dctd_ctrl.sv
// Sequencing state machine for the trial-division divisor counter.
module dctd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dctd_pkg::dctd_status_t status,
  output dctd_pkg::dctd_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_DIV    = 5'b00100,
    S_EVAL   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.v_zero || status.sq_gt_v) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.rem_zero) begin
          cmd.take_quot = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/dctd_datapath.sv
// Value, candidate, bit-serial divider, count and output register.
module dctd_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [dctd_pkg::NUMBER_W-1:0]     number,
  input  dctd_pkg::dctd_cmd_t               cmd,
  output dctd_pkg::dctd_status_t            status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dctd_pkg::COUNT_W-1:0]      divisor_count
);

  localparam int CAND_W = (VALUE_WIDTH + 1) / 2 + 2;
  localparam int SQ_W   = VALUE_WIDTH + 4;
  localparam int EXP_W  = $clog2(VALUE_WIDTH + 1);
  localparam int BIT_W  = $clog2(VALUE_WIDTH);
  localparam int PROD_W = dctd_pkg::COUNT_W + EXP_W + 1;

  logic [VALUE_WIDTH-1:0]        v;
  logic [VALUE_WIDTH-1:0]        q;
  logic [CAND_W-1:0]             cand;
  logic [CAND_W-1:0]             rem;
  logic [SQ_W-1:0]               sq;
  logic [EXP_W-1:0]              exp_cnt;
  logic [BIT_W-1:0]              bit_cnt;
  logic [dctd_pkg::COUNT_W-1:0]  count;

  logic [CAND_W:0]               trial;
  logic [CAND_W:0]               diff;
  logic                          fits;
  logic [EXP_W:0]                exp_inc;
  logic [PROD_W-1:0]             prod;
  logic [dctd_pkg::COUNT_W-1:0]  count_mul;
  logic [dctd_pkg::COUNT_W-1:0]  count_dbl;
  logic [dctd_pkg::COUNT_W-1:0]  result_val;

  assign trial = {rem, q[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, cand};
  assign diff  = trial - {1'b0, cand};

  assign exp_inc   = {1'b0, exp_cnt} + 1'b1;
  assign prod      = PROD_W'(count) * PROD_W'(exp_inc);
  assign count_mul = (prod > PROD_W'(dctd_pkg::COUNT_MAX)) ? dctd_pkg::COUNT_MAX
                                                           : prod[dctd_pkg::COUNT_W-1:0];
  assign count_dbl = count[dctd_pkg::COUNT_W-1] ? dctd_pkg::COUNT_MAX
                                                : {count[dctd_pkg::COUNT_W-2:0], 1'b0};

  always_comb begin
    if (v == '0) begin
      result_val = '0;
    end else if (v != VALUE_WIDTH'(1)) begin
      result_val = count_dbl;
    end else begin
      result_val = count;
    end
  end

  assign status.v_zero   = (v == '0);
  assign status.sq_gt_v  = sq > SQ_W'(v);
  assign status.div_last = (bit_cnt == '0);
  assign status.rem_zero = (rem == '0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v       <= VALUE_WIDTH'(number);
      cand    <= CAND_W'(2);
      sq      <= SQ_W'(4);
      exp_cnt <= '0;
      count   <= dctd_pkg::COUNT_W'(1);
    end
    if (cmd.div_start) begin
      q       <= v;
      rem     <= '0;
      bit_cnt <= BIT_W'(VALUE_WIDTH - 1);
    end
    if (cmd.div_step) begin
      q       <= {q[VALUE_WIDTH-2:0], fits};
      rem     <= fits ? diff[CAND_W-1:0] : trial[CAND_W-1:0];
      bit_cnt <= bit_cnt - 1'b1;
    end
    if (cmd.take_quot) begin
      v       <= q;
      exp_cnt <= exp_cnt + 1'b1;
      rem     <= '0;
      bit_cnt <= BIT_W'(VALUE_WIDTH - 1);
    end
    if (cmd.next_cand) begin
      count   <= count_mul;
      exp_cnt <= '0;
      if (cand == CAND_W'(2)) begin
        cand <= CAND_W'(3);
        sq   <= SQ_W'(9);
      end else begin
        cand <= cand + CAND_W'(2);
        sq   <= sq + SQ_W'({cand, 2'b00}) + SQ_W'(4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      divisor_count <= result_val;
    end
  end

endmodule

### rtl/divisor_count_trial_division.sv
// Divisor counter by trial division: one request value in, its number of
// positive divisors out. Candidates are 2 and then the odd numbers; each one
// is tested with a bit-serial restoring divider that retires one quotient bit
// per cycle, so a trial is a check, VALUE_WIDTH divide steps and an evaluate,
// and every further division by a factor that was found repeats the divide
// steps and the evaluate. Trial stops once the candidate squared exceeds
// what is left. One value is in work at a time; a new request is taken as
// soon as the previous result sits in the output register, even if that
// result has not yet been taken. Only the low VALUE_WIDTH bits of number are
// used; zero returns 0, and counts above 2047 (possible only above 32 bits)
// saturate to 2047.
module divisor_count_trial_division #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  dctd_req_if.sink    request,
  dctd_res_if.source  result
);

  dctd_pkg::dctd_cmd_t    cmd;
  dctd_pkg::dctd_status_t status;

  dctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dctd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .number        (request.number),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .divisor_count (result.divisor_count)
  );

endmodule

### rtl/dctd_checker.sv
// Port-level checks for the divisor counter, bound to the top level.
`include "divisor_count_trial_division_defines.svh"

module dctd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [dctd_pkg::COUNT_W-1:0]  divisor_count
);

  // Result held until transfer.
  `DCTD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(divisor_count), "result dropped before transfer")
  // One value in work at a time.
  `DCTD_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready, "request taken while busy")
  // Reset leaves no result pending.
  `DCTD_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, !res_valid, "result valid after reset")
  // A new result appears only while the block is busy.
  `DCTD_ASSERT_NOW(a_res_from_work, clk, rst, $rose(res_valid), !$past(req_ready), "result without work")

endmodule

bind divisor_count_trial_division dctd_checker u_dctd_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .divisor_count (result.divisor_count)
);

### tb/divisor_count_trial_division_tb.sv
// Self-checking testbench for the trial-division divisor counter.
module divisor_count_trial_division_tb;

  localparam int IDLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [dctd_pkg::NUMBER_W-1:0] number;
    logic [dctd_pkg::COUNT_W-1:0]  count;
  } count_req_t;

  logic clk;
  logic rst;

  dctd_req_if req_ch ();
  dctd_res_if res_ch ();

  count_req_t pending_counts[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         gaps_on;

  divisor_count_trial_division DUT (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [dctd_pkg::COUNT_W-1:0] divisor_count_of(
    logic [dctd_pkg::NUMBER_W-1:0] value);
    bit [63:0]   rest;
    bit [63:0]   cand;
    int unsigned tally;
    int unsigned power;
    rest = value;
    if (rest == 0) return '0;
    tally = 1;
    cand = 2;
    while (cand * cand <= rest) begin
      if (rest % cand == 0) begin
        power = 0;
        while (rest % cand == 0) begin
          rest = rest / cand;
          power++;
        end
        tally = tally * (power + 1);
      end
      cand = (cand == 2) ? 3 : cand + 2;
    end
    if (rest != 1) tally = tally * 2;
    if (tally > dctd_pkg::COUNT_MAX) tally = dctd_pkg::COUNT_MAX;
    return tally[dctd_pkg::COUNT_W-1:0];
  endfunction

  function automatic int draw_wait();
    return gaps_on ? $urandom_range(0, 15) : 0;
  endfunction

  // Random cofactor up to 16 bits padded with small primes toward the full width.
  function automatic logic [dctd_pkg::NUMBER_W-1:0] smooth_wide_value();
    int unsigned primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    bit [63:0] acc;
    bit [63:0] p;
    acc = $urandom_range(1, 65535);
    for (int i = 0; i < 40; i++) begin
      p = primes[$urandom_range(0, 24)];
      if (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
    end
    return acc[dctd_pkg::NUMBER_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_number(input logic [dctd_pkg::NUMBER_W-1:0] value);
    int gap;
    count_req_t entry;
    gap = draw_wait();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.number <= value;
    do @(posedge clk); while (!req_ch.ready);
    entry.number = value;
    entry.count  = divisor_count_of(value);
    pending_counts.insert(pending_counts.size(), entry);
    @(negedge clk);
  endtask

  // Result side stalls between transfers.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    count_req_t head;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("count %0d with no request waiting",
                                  res_ch.divisor_count));
      end else begin
        head = pending_counts.pop_front();
        if (res_ch.divisor_count !== head.count)
          report_mismatch($sformatf("number %0d: divisor_count %0d, want %0d",
                                    head.number, res_ch.divisor_count, head.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Zero, one, primes, squares, powers, high count, large leftover prime, bit patterns.
  task automatic test_directed_values();
    logic [dctd_pkg::NUMBER_W-1:0] values[18] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd36, 32'd97,
      32'd63001, 32'd65521, 32'd735134400, 32'h8000_0000, 32'hFFFF_FFFF,
      32'd3486784401, 32'd4293984256, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (values[i]) send_number(values[i]);
  endtask

  task automatic test_small_values();
    repeat (30) send_number($urandom_range(0, 4095));
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (15) send_number($urandom_range(1, 16383));
    gaps_on = 1'b1;
  endtask

  task automatic test_mid_values();
    repeat (25) send_number($urandom_range(4096, 65535));
  endtask

  task automatic test_smooth_wide_values();
    repeat (30) send_number(smooth_wide_value());
  endtask

  initial begin
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.number = '0;
    gaps_on       = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_values();
    test_small_values();
    test_back_to_back();
    test_mid_values();
    test_smooth_wide_values();

    req_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dctd_pkg.sv
rtl/dctd_ifs.sv
rtl/dctd_ctrl.sv
rtl/dctd_datapath.sv
rtl/divisor_count_trial_division.sv
rtl/dctd_checker.sv
tb/divisor_count_trial_division_tb.sv
